[rtl/wpwg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpwg_pkg
// Shared types, constants and table functions of the plane wave generator.
// ----------------------------------------------------------------------------
package wpwg_pkg;

	localparam int SINE_DEPTH_DEF = 1024;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_INDEX_W    = 3;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PROFILE_MODE = 3'd0,
		REG_AMPLITUDE    = 3'd1,
		REG_WAVE_VECTOR  = 3'd2,
		REG_ANGULAR_RATE = 3'd3,
		REG_PHASE_OFFSET = 3'd4,
		REG_TIME_WINDOW  = 3'd5,
		REG_RAMP_RATE    = 3'd6,
		REG_PACKET_SHAPE = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_PLAIN  = 2'd1,
		MODE_PACKET = 2'd2,
		MODE_ALT    = 2'd3
	} profile_mode_t;

	// sin(pi/2 * r), r in Q30; Q1.15 result, evaluated at elaboration
	function automatic int quarter_sine(input longint r);
		longint r2;
		longint acc;
		longint y;
		longint q;
		r2  = (r * r) >>> 30;
		acc = 64'sd172272;
		acc = -64'sd5026994 + ((acc * r2) >>> 30);
		acc = 64'sd85569306 + ((acc * r2) >>> 30);
		acc = -64'sd693598669 + ((acc * r2) >>> 30);
		acc = 64'sd1686629713 + ((acc * r2) >>> 30);
		y   = (acc * r) >>> 30;
		q   = (y + 64'sd16384) >>> 15;
		if (q < 0) q = 0;
		if (q > 32767) q = 32767;
		return int'(q);
	endfunction

	// 2^(-k/16) in Q16
	function automatic logic [16:0] exp2_val(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			5'd16: v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/wpwg_sine_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpwg_sine_lookup
// Quarter-wave sine table with quadrant folding; registered Q1.15 output.
// ----------------------------------------------------------------------------
module wpwg_sine_lookup #(
	parameter int DEPTH = wpwg_pkg::SINE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic [31:0]        phase,
	output logic signed [15:0] sine
);
	import wpwg_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int QN = DEPTH / 4;

	logic [14:0]   qrom [QN+1];
	logic [AW-1:0] idx;
	logic [1:0]    quad;
	logic [AW-2:0] jf;
	logic [AW-2:0] j;
	logic [15:0]   mag;
	logic signed [15:0] sine_s3;

	for (genvar gi = 0; gi <= QN; gi++) begin : g_rom
		localparam int QV = quarter_sine(longint'(gi) << (32 - AW));
		assign qrom[gi] = QV[14:0];
	end

	always_comb begin
		idx  = phase[31 -: AW];
		quad = idx[AW-1 -: 2];
		jf   = {1'b0, idx[AW-3:0]};
		j    = quad[0] ? (AW-1)'(QN) - jf : jf;
		mag  = {1'b0, qrom[j]};
	end

	always_ff @(posedge clk) begin
		sine_s3 <= quad[1] ? -$signed(mag) : $signed(mag);
	end

	assign sine = sine_s3;

endmodule

[rtl/windowed_plane_wave_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_plane_wave_generator_top
// Windowed plane-wave sample generator, six-stage pipeline.
// ----------------------------------------------------------------------------
// A sample request (start with time_tick and pos_x/y/z) is taken in every
// cycle; busy is always low. The result leaves the last stage with done
// high for exactly one cycle and must be captured then: there is no
// backpressure. Throughput is one sample per clock, set by the fully
// pipelined multiplier chain (phase products, ramp and packet products,
// three scaling multiplies). Configuration is written with cfg_we,
// cfg_index and cfg_data while no transfer is in flight.
// ----------------------------------------------------------------------------
module windowed_plane_wave_generator_top #(
	parameter int SINE_TABLE_DEPTH = wpwg_pkg::SINE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wpwg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wpwg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  logic [31:0]                        time_tick,
	input  logic signed [23:0]                 pos_x,
	input  logic signed [23:0]                 pos_y,
	input  logic signed [23:0]                 pos_z,
	output logic                               done,
	output logic signed [15:0]                 wave_value,
	output logic                               in_window
);
	import wpwg_pkg::*;

	// configuration registers
	logic [1:0]  profile_mode_q;
	logic [15:0] amplitude_q;
	logic [62:0] wave_vector_q;
	logic [31:0] angular_rate_q;
	logic [31:0] phase_offset_q;
	logic [63:0] time_window_q;
	logic [31:0] ramp_rate_q;
	logic [63:0] packet_shape_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_mode_q <= '0;
			amplitude_q    <= '0;
			wave_vector_q  <= '0;
			angular_rate_q <= '0;
			phase_offset_q <= '0;
			time_window_q  <= '0;
			ramp_rate_q    <= '0;
			packet_shape_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROFILE_MODE: profile_mode_q <= cfg_data[1:0];
				REG_AMPLITUDE:    amplitude_q    <= cfg_data[15:0];
				REG_WAVE_VECTOR:  wave_vector_q  <= cfg_data[62:0];
				REG_ANGULAR_RATE: angular_rate_q <= cfg_data[31:0];
				REG_PHASE_OFFSET: phase_offset_q <= cfg_data[31:0];
				REG_TIME_WINDOW:  time_window_q  <= cfg_data;
				REG_RAMP_RATE:    ramp_rate_q    <= cfg_data[31:0];
				REG_PACKET_SHAPE: packet_shape_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] win_start, win_end, centre, rw;
	assign win_start = time_window_q[63:32];
	assign win_end   = time_window_q[31:0];
	assign centre    = packet_shape_q[63:32];
	assign rw        = (packet_shape_q[31:0] == '0) ? 32'd65536 : packet_shape_q[31:0];

	logic transfer;
	assign busy     = 1'b0;
	assign transfer = start && !busy;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= transfer;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// ---- stage 1: position products, rate product, window, time deltas
	logic signed [44:0] px_prod, py_prod, pz_prod;
	logic [63:0] rt_prod;
	logic        inwin_c;
	assign px_prod = $signed(wave_vector_q[20:0]) * pos_x;
	assign py_prod = $signed(wave_vector_q[41:21]) * pos_y;
	assign pz_prod = $signed(wave_vector_q[62:42]) * pos_z;
	assign rt_prod = angular_rate_q * time_tick;
	assign inwin_c = (time_tick >= win_start) && ((win_end == '0) || (time_tick <= win_end));

	logic [31:0] kx_s1, ky_s1, kz_s1, rt_s1, dt_s1, ad_s1;
	logic        inwin_s1;
	always_ff @(posedge clk) begin
		kx_s1    <= px_prod[31:0];
		ky_s1    <= py_prod[31:0];
		kz_s1    <= pz_prod[31:0];
		rt_s1    <= rt_prod[31:0];
		dt_s1    <= time_tick - win_start;
		ad_s1    <= (time_tick >= centre) ? time_tick - centre : centre - time_tick;
		inwin_s1 <= inwin_c;
	end

	// ---- stage 2: phase sum, ramp fraction, packet tau
	logic [63:0] f_prod, tau_prod;
	assign f_prod   = dt_s1 * ramp_rate_q;
	assign tau_prod = ad_s1 * rw;

	logic [31:0] phase_s2, f_s2;
	logic        full_s2, tbig_s2, inwin_s2;
	logic [17:0] tau_s2;
	always_ff @(posedge clk) begin
		phase_s2 <= kx_s1 + ky_s1 + kz_s1 - rt_s1 + phase_offset_q;
		f_s2     <= f_prod[31:0];
		full_s2  <= (ramp_rate_q == '0) || (f_prod[63:32] != '0);
		tau_s2   <= tau_prod[17:0];
		tbig_s2  <= tau_prod[63:18] != '0;
		inwin_s2 <= inwin_s1;
	end

	// ---- stage 3: sine and ramp cosine lookups, tau squared
	logic [31:0] ramp_ph;
	logic signed [15:0] sine_s3, cos_s3;
	logic [35:0] tau_sq;
	assign ramp_ph = {1'b0, f_s2[31:1]} + 32'h4000_0000;
	assign tau_sq  = tau_s2 * tau_s2;

	wpwg_sine_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_sine (
		.clk(clk), .phase(phase_s2), .sine(sine_s3));
	wpwg_sine_lookup #(.DEPTH(SINE_TABLE_DEPTH)) u_cos (
		.clk(clk), .phase(ramp_ph), .sine(cos_s3));

	logic [19:0] s_s3;
	logic        full_s3, tbig_s3, inwin_s3;
	always_ff @(posedge clk) begin
		s_s3     <= tau_sq[35:16];
		full_s3  <= full_s2;
		tbig_s3  <= tbig_s2;
		inwin_s3 <= inwin_s2;
	end

	// ---- stage 4: amplitude scaling, ramp envelope, log2(e) scaling
	logic signed [31:0] amp_prod;
	logic [36:0] y_prod;
	assign amp_prod = $signed(amplitude_q) * sine_s3 + 32'sd16384;
	assign y_prod   = s_s3 * LOG2E_Q16;

	logic signed [16:0] v1_s4;
	logic [16:0] env_s4;
	logic [20:0] y_s4;
	logic        gz_s4, inwin_s4;
	always_ff @(posedge clk) begin
		v1_s4    <= amp_prod[31:15];
		env_s4   <= full_s3 ? 17'd65536 : 17'(18'sd32768 - 18'(cos_s3));
		y_s4     <= y_prod[36:16];
		gz_s4    <= tbig_s3 || (y_prod[36:32] >= 5'd17);
		inwin_s4 <= inwin_s3;
	end

	// ---- stage 5: ramp scaling, gaussian interpolation
	logic signed [34:0] env_prod;
	logic [16:0] ek, ek1, ediff, e_val;
	logic [23:0] interp;
	assign env_prod = v1_s4 * $signed({1'b0, env_s4}) + 35'sd32768;
	assign ek       = exp2_val({1'b0, y_s4[15:12]});
	assign ek1      = exp2_val(5'({1'b0, y_s4[15:12]} + 5'd1));
	assign ediff    = ek - ek1;
	assign interp   = ediff[11:0] * y_s4[11:0];
	assign e_val    = ek - 17'(interp[23:12]);

	logic signed [18:0] v2_s5;
	logic [16:0] g_s5;
	logic        inwin_s5;
	always_ff @(posedge clk) begin
		v2_s5    <= env_prod[34:16];
		g_s5     <= gz_s4 ? 17'd0 : (e_val >> y_s4[20:16]);
		inwin_s5 <= inwin_s4;
	end

	// ---- stage 6: packet scaling, clamp, output register
	logic signed [36:0] g_prod;
	logic signed [20:0] v3;
	logic signed [15:0] clamp_v;
	assign g_prod = v2_s5 * $signed({1'b0, g_s5}) + 37'sd32768;

	always_comb begin
		v3 = (profile_mode_q == MODE_PACKET) ? 21'(g_prod[36:16]) : 21'(v2_s5);
		if (v3 > 21'sd32767)
			clamp_v = 16'sh7FFF;
		else if (v3 < -21'sd32768)
			clamp_v = 16'sh8000;
		else
			clamp_v = v3[15:0];
	end

	logic signed [15:0] wave_s6;
	logic               inwin_s6;
	always_ff @(posedge clk) begin
		wave_s6  <= (inwin_s5 && profile_mode_q != MODE_OFF) ? clamp_v : 16'sd0;
		inwin_s6 <= inwin_s5;
	end

	assign done       = vld_s6;
	assign wave_value = wave_s6;
	assign in_window  = inwin_s6;

	// ---- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done) else $error("result strobe missing after transfer");
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_window) |-> (wave_value == 16'sd0))
		else $error("nonzero sample outside window");
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && profile_mode_q == MODE_OFF) |-> (wave_value == 16'sd0))
		else $error("nonzero sample while disabled");

endmodule
